// ===== rtl/pmsd_pkg.sv =====
// Shared types, constants and codes for the passive matrix surround decoder.
`default_nettype none
package pmsd_pkg;

    localparam int TAPS_DEF        = 32;
    localparam int DELAY_DEPTH_DEF = 65536;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEF_BITS_DEF   = 18;

    localparam int MIX_FRAC = 17;
    localparam int K_FRONT  = 92668;
    localparam int K_BIG    = 77044;
    localparam int K_SMALL  = 51485;

    localparam int DELAY_W      = 16;
    localparam int COEF_INDEX_W = 5;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd960;

    localparam logic ACTION_PROCESS = 1'b0;
    localparam logic ACTION_COEF    = 1'b1;

    localparam logic REG_DELAY_IDX = 1'b0;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_FIN,
        S_WRITE,
        S_READ,
        S_OUT
    } state_t;

    typedef enum logic [2:0] {
        PH_FIR_L,
        PH_FIR_R,
        PH_FRONT_L,
        PH_FRONT_R,
        PH_MIX_L,
        PH_MIX_R
    } phase_t;

    typedef struct packed {
        logic issue;
        logic neg;
        logic clr;
        logic fir_round;
    } mac_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/pmsd_in_if.sv =====
// Input channel interface: one beat is a sample pair or a coefficient write.
`default_nettype none
interface pmsd_in_if #(
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 18
);
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic [4:0]                    coef_index;
    logic signed [COEF_BITS-1:0]   coef_value;

    modport source (output valid, action, left_sample, right_sample, coef_index, coef_value,
                    input ready);
    modport sink (input valid, action, left_sample, right_sample, coef_index, coef_value,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/pmsd_out_if.sv =====
// Output channel interface: one beat carries the four decoded channels.
`default_nettype none
interface pmsd_out_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] front_left;
    logic signed [SAMPLE_BITS-1:0] front_right;
    logic signed [SAMPLE_BITS-1:0] rear_left;
    logic signed [SAMPLE_BITS-1:0] rear_right;

    modport source (output valid, front_left, front_right, rear_left, rear_right,
                    input ready);
    modport sink (input valid, front_left, front_right, rear_left, rear_right,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/pmsd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pmsd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// ===== rtl/pmsd_mac.sv =====
// Shared multiply-accumulate unit with round-half-up and saturation.
`default_nettype none
module pmsd_mac import pmsd_pkg::*; #(
    parameter int TAPS        = TAPS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = COEF_BITS_DEF
) (
    input  wire logic                                                  clk,
    input  wire logic                                                  rst_n,
    input  wire mac_ctrl_t                                             ctrl,
    input  wire logic signed [SAMPLE_BITS-1:0]                         a,
    input  wire logic signed [((COEF_BITS > 18) ? COEF_BITS : 18)-1:0] b,
    output logic signed [SAMPLE_BITS-1:0]                              result
);
    localparam int B_W   = (COEF_BITS > 18) ? COEF_BITS : 18;
    localparam int P_W   = SAMPLE_BITS + B_W;
    localparam int ACC_W = P_W + $clog2(TAPS) + 2;

    localparam logic signed [ACC_W-1:0] HALF_FIR = ACC_W'(1) << (COEF_BITS - 2);
    localparam logic signed [ACC_W-1:0] HALF_MIX = ACC_W'(1) << (MIX_FRAC - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI   = (ACC_W'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam logic signed [ACC_W-1:0] SAT_LO   = -SAT_HI - 1;

    logic signed [P_W-1:0]   prod_reg;
    logic                    pv_reg;
    logic                    neg_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] prod_ext;
    logic signed [ACC_W-1:0] rounded;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg  <= 1'b0;
            neg_reg <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            pv_reg  <= ctrl.issue;
            neg_reg <= ctrl.neg;
            if (ctrl.clr)
            begin
                acc_reg <= '0;
            end
            else if (pv_reg)
            begin
                acc_reg <= neg_reg ? (acc_reg - prod_ext) : (acc_reg + prod_ext);
            end
        end
    end

    always_comb
    begin
        prod_ext = ACC_W'(prod_reg);
        if (ctrl.fir_round)
        begin
            rounded = (acc_reg + HALF_FIR) >>> (COEF_BITS - 1);
        end
        else
        begin
            rounded = (acc_reg + HALF_MIX) >>> MIX_FRAC;
        end
        if (rounded > SAT_HI)
        begin
            result = SAT_HI[SAMPLE_BITS-1:0];
        end
        else if (rounded < SAT_LO)
        begin
            result = SAT_LO[SAMPLE_BITS-1:0];
        end
        else
        begin
            result = rounded[SAMPLE_BITS-1:0];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/passive_matrix_surround_decoder.sv =====
// Top level: sequencer, histories, tap weights, delay stores and APB register.
// A sample pair passes from accept to output beat through one shared MAC that steps both FIRs,
// the front gains and the rear mixes; no new beat is taken until its output beat is loaded.
// A coefficient write beat gives no output beat.
// After reset a clearing pass zeroes all DELAY_DEPTH entries of the delay stores
// (65536 by default) before the first beat is taken; APB writes are taken throughout.
`default_nettype none
module passive_matrix_surround_decoder import pmsd_pkg::*; #(
    parameter int TAPS        = TAPS_DEF,
    parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = COEF_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    pmsd_in_if.sink          in_ch,
    pmsd_out_if.source       out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    localparam int B_W = (COEF_BITS > 18) ? COEF_BITS : 18;
    localparam int HW  = $clog2(TAPS);
    localparam int AW  = $clog2(DELAY_DEPTH);

    state_t state_reg, state_next;
    phase_t ph_reg;
    logic [HW-1:0]      k_reg;
    logic [HW-1:0]      k_last;
    logic [HW-1:0]      hist_pos_reg;
    logic [AW-1:0]      rd_pos_reg;
    logic [AW-1:0]      clr_cnt_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic [DELAY_W-1:0] dm_reg;
    logic               out_valid_reg;

    logic signed [SAMPLE_BITS-1:0] hist_l_reg [TAPS];
    logic signed [SAMPLE_BITS-1:0] hist_r_reg [TAPS];
    logic signed [COEF_BITS-1:0]   weight_reg [TAPS];

    logic signed [SAMPLE_BITS-1:0] l_reg, r_reg;
    logic signed [SAMPLE_BITS-1:0] fir_l_reg, fir_r_reg, fl_reg, fr_reg, ml_reg, mr_reg;
    logic signed [SAMPLE_BITS-1:0] out_fl_reg, out_fr_reg, out_rl_reg, out_rr_reg;

    mac_ctrl_t                     mac_ctrl;
    logic signed [SAMPLE_BITS-1:0] mac_a;
    logic signed [B_W-1:0]         mac_b;
    logic signed [SAMPLE_BITS-1:0] mac_result;

    logic            in_beat;
    logic            dm_ok;
    logic            out_free;
    logic            ram_we;
    logic            ram_re;
    logic            out_load;
    logic [AW-1:0]   ram_waddr;
    logic [SAMPLE_BITS-1:0] ram_wdata_l, ram_wdata_r;
    logic [SAMPLE_BITS-1:0] ram_rdata_l, ram_rdata_r;
    logic [AW:0]     wr_sum;
    logic [AW-1:0]   wr_addr;
    logic [HW:0]     h_sum;
    logic [HW-1:0]   h_idx;
    logic            cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_DELAY_IDX);
    assign prdata    = (paddr[2] == REG_DELAY_IDX) ? 32'(delay_reg) : 32'd0;

    assign in_beat  = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign dm_ok    = ({1'b0, dm_reg} < (DELAY_W + 1)'(DELAY_DEPTH));

    assign wr_sum  = {1'b0, rd_pos_reg} + (AW + 1)'(dm_reg);
    assign wr_addr = (wr_sum >= (AW + 1)'(DELAY_DEPTH)) ?
                     AW'(wr_sum - (AW + 1)'(DELAY_DEPTH)) : wr_sum[AW-1:0];

    assign h_sum = (HW + 1)'(hist_pos_reg) + (HW + 1)'(k_reg);
    assign h_idx = (h_sum >= (HW + 1)'(TAPS)) ? HW'(h_sum - (HW + 1)'(TAPS)) : h_sum[HW-1:0];

    always_comb
    begin
        unique case (ph_reg)
            PH_FIR_L, PH_FIR_R:     k_last = HW'(TAPS - 1);
            PH_FRONT_L, PH_FRONT_R: k_last = '0;
            default:                k_last = HW'(1);
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == AW'(DELAY_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_beat && (in_ch.action == ACTION_PROCESS))
                begin
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                if (k_reg == k_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: state_next = S_FIN;
            S_FIN:   state_next = (ph_reg == PH_MIX_R) ? S_WRITE : S_MAC;
            S_WRITE:
            begin
                if (dm_ok)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:  state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ch.ready        = (state_reg == S_IDLE);
        mac_ctrl.issue     = (state_reg == S_MAC);
        mac_ctrl.clr       = (state_reg == S_FIN);
        mac_ctrl.fir_round = (ph_reg == PH_FIR_L) || (ph_reg == PH_FIR_R);
        mac_ctrl.neg       = ((ph_reg == PH_MIX_L) || (ph_reg == PH_MIX_R)) && (k_reg != '0);
        ram_we             = (state_reg == S_CLEAR) || ((state_reg == S_WRITE) && dm_ok);
        ram_re             = (state_reg == S_READ);
        out_load           = (state_reg == S_OUT) && out_free;
        if (state_reg == S_CLEAR)
        begin
            ram_waddr   = clr_cnt_reg;
            ram_wdata_l = '0;
            ram_wdata_r = '0;
        end
        else
        begin
            ram_waddr   = wr_addr;
            ram_wdata_l = fir_l_reg;
            ram_wdata_r = fir_r_reg;
        end
        unique case (ph_reg)
            PH_FIR_L:
            begin
                mac_a = hist_l_reg[h_idx];
                mac_b = B_W'(weight_reg[k_reg]);
            end
            PH_FIR_R:
            begin
                mac_a = hist_r_reg[h_idx];
                mac_b = B_W'(weight_reg[k_reg]);
            end
            PH_FRONT_L:
            begin
                mac_a = l_reg;
                mac_b = B_W'(K_FRONT);
            end
            PH_FRONT_R:
            begin
                mac_a = r_reg;
                mac_b = B_W'(K_FRONT);
            end
            PH_MIX_L:
            begin
                mac_a = (k_reg == '0) ? l_reg : r_reg;
                mac_b = (k_reg == '0) ? B_W'(K_SMALL) : B_W'(K_BIG);
            end
            default:
            begin
                mac_a = (k_reg == '0) ? l_reg : r_reg;
                mac_b = (k_reg == '0) ? B_W'(K_BIG) : B_W'(K_SMALL);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ph_reg        <= PH_FIR_L;
            k_reg         <= '0;
            hist_pos_reg  <= '0;
            rd_pos_reg    <= '0;
            clr_cnt_reg   <= '0;
            delay_reg     <= DELAY_RESET;
            dm_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TAPS; i++)
            begin
                hist_l_reg[i] <= '0;
                hist_r_reg[i] <= '0;
                weight_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                delay_reg <= pwdata[DELAY_W-1:0];
            end
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (in_beat && (in_ch.action == ACTION_COEF) &&
                (int'(in_ch.coef_index) < TAPS))
            begin
                weight_reg[HW'(in_ch.coef_index)] <= in_ch.coef_value;
            end
            if (in_beat)
            begin
                dm_reg <= delay_reg;
                ph_reg <= PH_FIR_L;
                k_reg  <= '0;
            end
            else if (!dm_ok)
            begin
                dm_reg <= dm_reg - DELAY_W'(DELAY_DEPTH);
            end
            if (state_reg == S_MAC)
            begin
                k_reg <= (k_reg == k_last) ? '0 : k_reg + 1'b1;
            end
            if (state_reg == S_FIN)
            begin
                unique case (ph_reg)
                    PH_FIR_L:   ph_reg <= PH_FIR_R;
                    PH_FIR_R:   ph_reg <= PH_FRONT_L;
                    PH_FRONT_L: ph_reg <= PH_FRONT_R;
                    PH_FRONT_R: ph_reg <= PH_MIX_L;
                    PH_MIX_L:   ph_reg <= PH_MIX_R;
                    default:    ph_reg <= PH_FIR_L;
                endcase
            end
            if (out_load)
            begin
                out_valid_reg            <= 1'b1;
                rd_pos_reg               <= (rd_pos_reg == AW'(DELAY_DEPTH - 1)) ?
                                            '0 : rd_pos_reg + 1'b1;
                hist_l_reg[hist_pos_reg] <= ml_reg;
                hist_r_reg[hist_pos_reg] <= mr_reg;
                hist_pos_reg             <= (hist_pos_reg == '0) ?
                                            HW'(TAPS - 1) : hist_pos_reg - 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            l_reg <= in_ch.left_sample;
            r_reg <= in_ch.right_sample;
        end
        if (state_reg == S_FIN)
        begin
            unique case (ph_reg)
                PH_FIR_L:   fir_l_reg <= mac_result;
                PH_FIR_R:   fir_r_reg <= mac_result;
                PH_FRONT_L: fl_reg    <= mac_result;
                PH_FRONT_R: fr_reg    <= mac_result;
                PH_MIX_L:   ml_reg    <= mac_result;
                default:    mr_reg    <= mac_result;
            endcase
        end
        if (out_load)
        begin
            out_fl_reg <= fl_reg;
            out_fr_reg <= fr_reg;
            out_rl_reg <= ram_rdata_l;
            out_rr_reg <= ram_rdata_r;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.front_left  = out_fl_reg;
    assign out_ch.front_right = out_fr_reg;
    assign out_ch.rear_left   = out_rl_reg;
    assign out_ch.rear_right  = out_rr_reg;

    pmsd_mac #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .a      (mac_a),
        .b      (mac_b),
        .result (mac_result)
    );

    pmsd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DELAY_DEPTH)
    ) u_store_l (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata_l),
        .re    (ram_re),
        .raddr (rd_pos_reg),
        .rdata (ram_rdata_l)
    );

    pmsd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DELAY_DEPTH)
    ) u_store_r (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata_r),
        .re    (ram_re),
        .raddr (rd_pos_reg),
        .rdata (ram_rdata_r)
    );

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE && ram_we) |-> dm_ok)
        else $error("delay store written before delay was reduced");

    a_rd_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(rd_pos_reg) < DELAY_DEPTH)
        else $error("read position beyond delay store");

    a_hist_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(hist_pos_reg) < TAPS)
        else $error("history position beyond taps");

    a_out_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && !out_free) |=> ($stable(rd_pos_reg) && $stable(hist_pos_reg)))
        else $error("positions advanced while output beat stalled");

endmodule
`default_nettype wire

// ===== verif/passive_matrix_surround_decoder_tb.sv =====
// Testbench for the passive matrix surround decoder: directed table, random beats, predictor.
`default_nettype none
module passive_matrix_surround_decoder_tb;
    import pmsd_pkg::*;

    localparam int SW = 24;
    localparam int CW = 18;
    localparam int NTAPS = 32;
    localparam int DEPTH = 65536;
    localparam int STALL_LIMIT = 200000;

    typedef struct {
        logic                 action;
        logic signed [SW-1:0] left;
        logic signed [SW-1:0] right;
        logic [4:0]           tap;
        logic signed [CW-1:0] weight;
    } beat_t;

    typedef struct {
        logic signed [SW-1:0] fl;
        logic signed [SW-1:0] fr;
        logic signed [SW-1:0] rl;
        logic signed [SW-1:0] rr;
    } quad_t;

    typedef struct {
        beat_t b;
        bit    typed;
        quad_t q;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pmsd_in_if #(.SAMPLE_BITS(SW), .COEF_BITS(CW)) in_bus ();
    pmsd_out_if #(.SAMPLE_BITS(SW)) out_bus ();

    passive_matrix_surround_decoder DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_bus),
        .out_ch  (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    longint               rear_hist_l [NTAPS];
    longint               rear_hist_r [NTAPS];
    longint               tap_weight [NTAPS];
    logic signed [SW-1:0] delay_line_l [DEPTH];
    logic signed [SW-1:0] delay_line_r [DEPTH];
    int unsigned          hist_ptr;
    int unsigned          read_ptr;
    int unsigned          rear_delay;

    quad_t decoded_queue [$];
    int    mismatches;
    int    idle_cycles;
    int    stall_mode;
    row_t  table_rows [$];

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint round_clamp(longint v, int frac);
        longint r;
        r = (v + (longint'(1) <<< (frac - 1))) >>> frac;
        if (r > 64'sd8388607)
            r = 64'sd8388607;
        if (r < -64'sd8388608)
            r = -64'sd8388608;
        return r;
    endfunction

    function automatic longint lowpass(ref longint h [NTAPS]);
        longint acc;
        acc = 0;
        for (int k = 0; k < NTAPS; k++)
            acc += tap_weight[k] * h[(hist_ptr + k) % NTAPS];
        return round_clamp(acc, CW - 1);
    endfunction

    function automatic bit decode_pair(beat_t b, output quad_t q);
        longint      l;
        longint      r;
        int unsigned wr;
        q = '{default: '0};
        if (b.action == ACTION_COEF)
        begin
            tap_weight[b.tap] = longint'(b.weight);
            return 1'b0;
        end
        l = longint'(b.left);
        r = longint'(b.right);
        q.fl = SW'(round_clamp(l * K_FRONT, MIX_FRAC));
        q.fr = SW'(round_clamp(r * K_FRONT, MIX_FRAC));
        wr = (read_ptr + rear_delay) % DEPTH;
        delay_line_l[wr] = SW'(lowpass(rear_hist_l));
        delay_line_r[wr] = SW'(lowpass(rear_hist_r));
        q.rl = delay_line_l[read_ptr];
        q.rr = delay_line_r[read_ptr];
        read_ptr = (read_ptr + 1) % DEPTH;
        rear_hist_l[hist_ptr] = round_clamp(l * K_SMALL - r * K_BIG, MIX_FRAC);
        rear_hist_r[hist_ptr] = round_clamp(l * K_BIG - r * K_SMALL, MIX_FRAC);
        hist_ptr = (hist_ptr + NTAPS - 1) % NTAPS;
        return 1'b1;
    endfunction

    function automatic logic signed [SW-1:0] pick_sample();
        case ($urandom_range(7))
            0: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
            1: return SW'($signed($urandom_range(512)) - 256);
            default: return SW'($urandom);
        endcase
    endfunction

    function automatic beat_t random_beat();
        beat_t b;
        b.action = ($urandom_range(9) == 0) ? ACTION_COEF : ACTION_PROCESS;
        b.left   = pick_sample();
        b.right  = pick_sample();
        b.tap    = 5'($urandom);
        if ($urandom_range(1))
            b.weight = CW'($urandom);
        else
            b.weight = CW'($signed($urandom_range(8192)) - 4096);
        return b;
    endfunction

    task automatic send_beat(beat_t b, bit typed, quad_t q, int gap);
        quad_t p;
        in_bus.valid        <= 1'b1;
        in_bus.action       <= b.action;
        in_bus.left_sample  <= b.left;
        in_bus.right_sample <= b.right;
        in_bus.coef_index   <= b.tap;
        in_bus.coef_value   <= b.weight;
        do
            @(posedge clk);
        while (!in_bus.ready);
        if (decode_pair(b, p))
            decoded_queue.push_back(typed ? q : p);
        if (gap > 0)
        begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_delay(int unsigned value);
        wait (decoded_queue.size() == 0);
        repeat (100) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'({REG_DELAY_IDX, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rear_delay = value % DEPTH;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_random(int count);
        int burst;
        burst = 0;
        for (int i = 0; i < count; i++)
        begin
            if (burst == 0)
                burst = $urandom_range(40, 1);
            burst--;
            send_beat(random_beat(), 1'b0, '{default: '0},
                      (burst == 0) ? $urandom_range(150) : 0);
        end
    endtask

    function automatic void add_row(logic act, int l, int r, int tap, int w, bit typed,
                                    int fl, int fr);
        row_t row;
        row.b     = '{act, SW'(l), SW'(r), 5'(tap), CW'(w)};
        row.typed = typed;
        row.q     = '{SW'(fl), SW'(fr), '0, '0};
        table_rows.push_back(row);
    endfunction

    // receiver stall pattern
    always @(posedge clk)
    begin
        if ($urandom_range(199) == 0)
            stall_mode <= $urandom_range(3);
        case (stall_mode)
            0: out_bus.ready <= 1'b1;
            1: out_bus.ready <= ($urandom_range(3) != 0);
            2: out_bus.ready <= ($urandom_range(3) == 0);
            default: out_bus.ready <= ($urandom_range(63) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        quad_t want;
        if (out_bus.valid && out_bus.ready)
        begin
            if (decoded_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output beat at %0t", $realtime);
            end
            else
            begin
                want = decoded_queue.pop_front();
                if (want.fl !== out_bus.front_left || want.fr !== out_bus.front_right
                    || want.rl !== out_bus.rear_left || want.rr !== out_bus.rear_right)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at %0t: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                                 $realtime, want.fl, want.fr, want.rl, want.rr,
                                 out_bus.front_left, out_bus.front_right,
                                 out_bus.rear_left, out_bus.rear_right);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int unsigned delays [6];
        in_bus.valid        = 1'b0;
        in_bus.action       = ACTION_PROCESS;
        in_bus.left_sample  = '0;
        in_bus.right_sample = '0;
        in_bus.coef_index   = '0;
        in_bus.coef_value   = '0;
        out_bus.ready       = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        stall_mode          = 0;
        mismatches          = 0;
        idle_cycles         = 0;
        rst_n               = 1'b0;
        for (int k = 0; k < NTAPS; k++)
        begin
            rear_hist_l[k] = 0;
            rear_hist_r[k] = 0;
            tap_weight[k]  = 0;
        end
        for (int a = 0; a < DEPTH; a++)
        begin
            delay_line_l[a] = '0;
            delay_line_r[a] = '0;
        end
        hist_ptr   = 0;
        read_ptr   = 0;
        rear_delay = DELAY_RESET;

        add_row(ACTION_PROCESS, 0, 0, 0, 0, 1'b1, 0, 0);
        add_row(ACTION_PROCESS, 8388607, 8388607, 0, 0, 1'b1, 5930751, 5930751);
        add_row(ACTION_PROCESS, -8388608, -8388608, 0, 0, 1'b1, -5930752, -5930752);
        add_row(ACTION_PROCESS, 8388607, -8388608, 0, 0, 1'b1, 5930751, -5930752);
        add_row(ACTION_COEF, 8388607, -1, 0, 131071, 1'b0, 0, 0);
        add_row(ACTION_COEF, 0, 0, 31, -131072, 1'b0, 0, 0);
        add_row(ACTION_COEF, 0, 0, 1, 65536, 1'b0, 0, 0);
        add_row(ACTION_COEF, 0, 0, 16, -1, 1'b0, 0, 0);
        add_row(ACTION_PROCESS, -8388608, 8388607, 0, 0, 1'b0, 0, 0);
        add_row(ACTION_PROCESS, 8388607, 8388607, 0, 0, 1'b0, 0, 0);
        add_row(ACTION_PROCESS, 1, -1, 0, 0, 1'b0, 0, 0);
        add_row(ACTION_PROCESS, -1, 1, 0, 0, 1'b0, 0, 0);
        add_row(ACTION_PROCESS, 0, 0, 0, 0, 1'b0, 0, 0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (table_rows[i])
            send_beat(table_rows[i].b, table_rows[i].typed, table_rows[i].q,
                      $urandom_range(3));
        run_random(200);

        delays = '{0, 65535, 1, 2, 960, 0};
        delays[3] = $urandom_range(64, 2);
        foreach (delays[p])
        begin
            in_bus.valid <= 1'b0;
            write_delay(delays[p]);
            run_random(130);
            // hold off until every pending beat has drained
            in_bus.valid <= 1'b0;
            wait (decoded_queue.size() == 0);
            @(posedge clk);
            run_random(130);
        end

        in_bus.valid <= 1'b0;
        wait (decoded_queue.size() == 0);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && decoded_queue.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire
